// File: rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, constants, tables and rounding helpers of the quaternion unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 24;
    localparam int NORM_BITS = 30;
    localparam int WIDE_W    = 2 * DATA_W + 2;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [2:0] {
        KIND_CONJ      = 3'd0,
        KIND_MUL       = 3'd1,
        KIND_ROT       = 3'd2,
        KIND_RATE_G    = 3'd3,
        KIND_RATE_L    = 3'd4,
        KIND_NORM_SQ   = 3'd5,
        KIND_NORMALIZE = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [3:0] neg;
        logic       zero;
    } ctl_t;

    localparam logic signed [WIDE_W-1:0] SAT_MAX =
        {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_MIN =
        {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] RND_HALF = WIDE_W'(1) <<< (FRAC_W - 1);

    // product term (i,j) of the Hamilton product uses a[j] * b[MUL_B[i][j]]
    localparam logic [1:0] MUL_B [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam bit MUL_NEG [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0}
    };

    // rate term (i,j) uses a[RATE_A[i][j]] * w[j]
    localparam logic [1:0] RATE_A [4][3] = '{
        '{2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd0, 2'd1},
        '{2'd2, 2'd1, 2'd0}
    };
    localparam bit RATE_NEG [2][4][3] = '{
        '{'{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b1},
          '{1'b1, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b0}},
        '{'{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0},
          '{1'b0, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b0}}
    };

    // pairwise products: p00 p11 p22 p33 p12 p03 p13 p02 p23 p01
    localparam logic [1:0] SQ_I [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                         2'd0, 2'd1, 2'd0, 2'd2, 2'd0};
    localparam logic [1:0] SQ_J [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2,
                                         2'd3, 2'd3, 2'd2, 2'd3, 2'd1};

    // {overflow, value}
    function automatic logic [DATA_W:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic [DATA_W:0] r;
        if (v > SAT_MAX) begin
            r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (v < SAT_MIN) begin
            r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [DATA_W:0] fx_round(input logic signed [2*DATA_W-1:0] p);
        logic signed [WIDE_W-1:0] t;
        t = (WIDE_W'(p) + RND_HALF) >>> FRAC_W;
        return sat_wide(t);
    endfunction

endpackage

// File: rtl/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Pipelined fixed-point quaternion unit: conjugate, product, rotation, rates,
// squared norm and normalize, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; the whole pipeline holds on a stall.
// Depth is set by the normalize path: 31 square-root stages and 26 divider
// stages, one result bit each, behind the magnitude scaling stages.
// Reset clears all valid bits and the output valid; payload is not reset.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a0, a1, a2, a3, b0, b1, b2, b3
    input  logic [8*qau_pkg::DATA_W-1:0]   s_tdata,
    // kind
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // r0, r1, r2, r3
    output logic [4*qau_pkg::DATA_W-1:0]   m_tdata,
    // status
    output logic [1:0]                     m_tuser
);

    localparam int W         = qau_pkg::DATA_W;
    localparam int F         = qau_pkg::FRAC_W;
    localparam int NB        = qau_pkg::NORM_BITS;
    localparam int WIDE      = qau_pkg::WIDE_W;
    localparam int GROUPS    = W / 8;
    localparam int BLW       = $clog2(W + 1);
    localparam int SQW       = 2 * NB + 2;
    localparam int LW        = NB + 1;
    localparam int DW        = NB + F;
    localparam int SQ_STEPS  = NB + 1;
    localparam int DIV_STEPS = F + 2;
    localparam int MAIN_END  = 7;
    localparam int SQ0       = 7;
    localparam int SQ_END    = SQ0 + SQ_STEPS;
    localparam int LAST      = SQ_END + DIV_STEPS;

    logic adv;

    qau_pkg::ctl_t ctl_reg  [1:LAST];
    qau_pkg::ctl_t ctl_next [1:LAST];

    qau_pkg::word_t a1_reg [4], a1_next [4], b1_reg [4], b1_next [4];
    qau_pkg::word_t a2_reg [4], b2_reg [4], a3_reg [4], b3_reg [4];
    logic signed [2*W-1:0] prod_reg [16], prod_next [16];
    logic [W-1:0] mag2_reg [4], mag2_next [4], mag3_reg [4], mag4_reg [4];
    logic [W-1:0] orv2_reg, orv2_next;
    qau_pkg::word_t fx3_reg [16], fx3_next [16];
    logic flag3_reg, flag3_next;
    logic [3:0] grp3_reg [GROUPS], grp3_next [GROUPS];
    qau_pkg::word_t r4_reg [4], r4_next [4], m4_reg [9], m4_next [9], b4_reg [3];
    logic flag4_reg, flag4_next;
    logic [BLW-1:0] bl4_reg, bl4_next;
    logic signed [2*W-1:0] prod5_reg [9], prod5_next [9];
    qau_pkg::word_t r5_reg [4], r6_reg [4];
    logic flag5_reg, flag6_reg, flag6_next;
    qau_pkg::word_t fx6_reg [9], fx6_next [9];
    logic [NB-1:0] nm_reg [5:SQ_END][4];
    logic [NB-1:0] nm5_next [4];
    logic [2*NB-1:0] sq6_reg [4], sq6_next [4];
    qau_pkg::word_t mres_reg [MAIN_END:LAST][4];
    qau_pkg::word_t r7_next [4];
    logic mflag_reg [MAIN_END:LAST];
    logic flag7_next;
    logic [SQW-1:0] sqn_reg [SQ0:SQ_END], sqn_next [SQ0:SQ_END];
    logic [SQW-1:0] sqr_reg [SQ0:SQ_END], sqr_next [SQ0:SQ_END];
    logic [LW-1:0] dvr_reg [1:DIV_STEPS][4], dvr_next [1:DIV_STEPS][4];
    logic [LW-1:0] dvr_src [0:DIV_STEPS-1][4];
    logic [DIV_STEPS-1:0] dvlo_reg [1:DIV_STEPS][4], dvlo_next [1:DIV_STEPS][4];
    logic [DIV_STEPS-1:0] dvlo_src [0:DIV_STEPS-1][4];
    logic [DIV_STEPS-1:0] dvq_reg [1:DIV_STEPS][4], dvq_next [1:DIV_STEPS][4];
    logic [DIV_STEPS-1:0] dvq_src [0:DIV_STEPS-1][4];
    logic [LW-1:0] dvl_reg [1:DIV_STEPS], dvl_next [1:DIV_STEPS];
    logic [LW-1:0] dvl_src [0:DIV_STEPS-1];

    logic out_valid_reg;
    logic [4*W-1:0] out_data_reg, out_data_next;
    logic [1:0] out_user_reg, out_user_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // control pipeline
    always_comb
    begin
        ctl_next[1].valid = s_tvalid;
        ctl_next[1].kind  = qau_pkg::kind_t'(s_tuser);
        ctl_next[1].neg   = '0;
        ctl_next[1].zero  = 1'b0;
        for (int k = 2; k <= LAST; k++) begin
            ctl_next[k] = ctl_reg[k-1];
        end
        ctl_next[2].neg  = {a1_reg[3][W-1], a1_reg[2][W-1], a1_reg[1][W-1], a1_reg[0][W-1]};
        ctl_next[3].zero = (orv2_reg == '0);
    end

    // stage 1 and stage 2
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            a1_next[i] = s_tdata[i*W +: W];
            b1_next[i] = s_tdata[(4+i)*W +: W];
        end
        orv2_next = '0;
        for (int i = 0; i < 4; i++) begin
            mag2_next[i] = a1_reg[i][W-1] ? (~a1_reg[i] + W'(1)) : a1_reg[i];
            orv2_next    = orv2_next | mag2_next[i];
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                qau_pkg::word_t x;
                qau_pkg::word_t y;
                x = '0;
                y = '0;
                case (ctl_reg[1].kind)
                    qau_pkg::KIND_MUL:
                    begin
                        x = a1_reg[j];
                        y = b1_reg[qau_pkg::MUL_B[i][j]];
                    end
                    qau_pkg::KIND_RATE_G, qau_pkg::KIND_RATE_L:
                    begin
                        if (j < 3) begin
                            x = a1_reg[qau_pkg::RATE_A[i][j]];
                            y = b1_reg[j];
                        end
                    end
                    qau_pkg::KIND_ROT, qau_pkg::KIND_NORM_SQ:
                    begin
                        if (4*i + j < 10) begin
                            x = a1_reg[qau_pkg::SQ_I[4*i+j]];
                            y = a1_reg[qau_pkg::SQ_J[4*i+j]];
                        end
                    end
                    default:
                    begin
                        x = '0;
                        y = '0;
                    end
                endcase
                prod_next[4*i+j] = x * y;
            end
        end
    end

    // stage 3
    always_comb
    begin
        logic [W:0] sv;
        flag3_next = 1'b0;
        for (int n = 0; n < 16; n++) begin
            sv          = qau_pkg::fx_round(prod_reg[n]);
            fx3_next[n] = sv[W-1:0];
            flag3_next  = flag3_next | sv[W];
        end
        for (int g = 0; g < GROUPS; g++) begin
            grp3_next[g] = '0;
            for (int t = 0; t < 8; t++) begin
                if (orv2_reg[g*8+t]) begin
                    grp3_next[g] = 4'(t + 1);
                end
            end
        end
    end

    // stage 4
    always_comb
    begin
        logic signed [WIDE-1:0] s;
        logic signed [WIDE-1:0] pw [10];
        logic signed [WIDE-1:0] ms [9];
        logic [W:0] sv;
        logic rl;
        s  = '0;
        sv = '0;
        for (int n = 0; n < 9; n++) begin
            ms[n] = '0;
        end
        flag4_next = flag3_reg;
        rl = (ctl_reg[3].kind == qau_pkg::KIND_RATE_L);
        for (int i = 0; i < 4; i++) begin
            r4_next[i] = '0;
        end
        for (int n = 0; n < 9; n++) begin
            m4_next[n] = '0;
        end
        for (int n = 0; n < 10; n++) begin
            pw[n] = WIDE'(fx3_reg[n]);
        end
        case (ctl_reg[3].kind)
            qau_pkg::KIND_CONJ:
            begin
                r4_next[0] = a3_reg[0];
                for (int i = 1; i < 4; i++) begin
                    sv         = qau_pkg::sat_wide(-WIDE'(a3_reg[i]));
                    r4_next[i] = sv[W-1:0];
                    flag4_next = flag4_next | sv[W];
                end
            end
            qau_pkg::KIND_MUL:
            begin
                for (int i = 0; i < 4; i++) begin
                    s = '0;
                    for (int j = 0; j < 4; j++) begin
                        if (qau_pkg::MUL_NEG[i][j]) begin
                            s = s - WIDE'(fx3_reg[4*i+j]);
                        end
                        else begin
                            s = s + WIDE'(fx3_reg[4*i+j]);
                        end
                    end
                    sv         = qau_pkg::sat_wide(s);
                    r4_next[i] = sv[W-1:0];
                    flag4_next = flag4_next | sv[W];
                end
            end
            qau_pkg::KIND_RATE_G, qau_pkg::KIND_RATE_L:
            begin
                for (int i = 0; i < 4; i++) begin
                    s = '0;
                    for (int j = 0; j < 3; j++) begin
                        if (qau_pkg::RATE_NEG[rl][i][j]) begin
                            s = s - WIDE'(fx3_reg[4*i+j]);
                        end
                        else begin
                            s = s + WIDE'(fx3_reg[4*i+j]);
                        end
                    end
                    s          = (s + WIDE'(1)) >>> 1;
                    sv         = qau_pkg::sat_wide(s);
                    r4_next[i] = sv[W-1:0];
                    flag4_next = flag4_next | sv[W];
                end
            end
            qau_pkg::KIND_NORM_SQ:
            begin
                sv         = qau_pkg::sat_wide(pw[0] + pw[1] + pw[2] + pw[3]);
                r4_next[0] = sv[W-1:0];
                flag4_next = flag4_next | sv[W];
            end
            qau_pkg::KIND_ROT:
            begin
                ms[0] = pw[0] + pw[1] - pw[2] - pw[3];
                ms[4] = pw[0] - pw[1] + pw[2] - pw[3];
                ms[8] = pw[0] - pw[1] - pw[2] + pw[3];
                ms[1] = pw[4] + pw[4] - pw[5] - pw[5];
                ms[2] = pw[6] + pw[6] + pw[7] + pw[7];
                ms[3] = pw[4] + pw[4] + pw[5] + pw[5];
                ms[5] = pw[8] + pw[8] - pw[9] - pw[9];
                ms[6] = pw[6] + pw[6] - pw[7] - pw[7];
                ms[7] = pw[8] + pw[8] + pw[9] + pw[9];
                for (int n = 0; n < 9; n++) begin
                    sv         = qau_pkg::sat_wide(ms[n]);
                    m4_next[n] = sv[W-1:0];
                    flag4_next = flag4_next | sv[W];
                end
            end
            default:
            begin
                flag4_next = flag3_reg;
            end
        endcase
        bl4_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (grp3_reg[g] != '0) begin
                bl4_next = BLW'(g * 8) + BLW'(grp3_reg[g]);
            end
        end
    end

    // stages 5 to 7
    always_comb
    begin
        logic [W+NB-1:0] sh;
        logic signed [WIDE-1:0] s;
        logic [W:0] sv;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod5_next[3*i+j] = m4_reg[3*i+j] * b4_reg[j];
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (bl4_reg > BLW'(NB)) begin
                sh = {{NB{1'b0}}, mag4_reg[i]} >> (bl4_reg - BLW'(NB));
            end
            else begin
                sh = {{NB{1'b0}}, mag4_reg[i]} << (BLW'(NB) - bl4_reg);
            end
            nm5_next[i] = sh[NB-1:0];
            sq6_next[i] = (2*NB)'(nm_reg[5][i]) * (2*NB)'(nm_reg[5][i]);
        end
        flag6_next = flag5_reg;
        for (int n = 0; n < 9; n++) begin
            sv          = qau_pkg::fx_round(prod5_reg[n]);
            fx6_next[n] = sv[W-1:0];
            flag6_next  = flag6_next | sv[W];
        end
        flag7_next = flag6_reg;
        r7_next    = r6_reg;
        if (ctl_reg[6].kind == qau_pkg::KIND_ROT) begin
            for (int i = 0; i < 3; i++) begin
                s = WIDE'(fx6_reg[3*i]) + WIDE'(fx6_reg[3*i+1]) + WIDE'(fx6_reg[3*i+2]);
                sv         = qau_pkg::sat_wide(s);
                r7_next[i] = sv[W-1:0];
                flag7_next = flag7_next | sv[W];
            end
            r7_next[3] = '0;
        end
    end

    // square root, one result bit per stage
    always_comb
    begin
        logic [SQW-1:0] bitv;
        logic [SQW:0]   t;
        sqn_next[SQ0] = SQW'(sq6_reg[0]) + SQW'(sq6_reg[1]) + SQW'(sq6_reg[2])
                      + SQW'(sq6_reg[3]);
        sqr_next[SQ0] = '0;
        for (int k = SQ0 + 1; k <= SQ_END; k++) begin
            bitv = SQW'(1) << (2 * (SQ_END - k));
            t    = {1'b0, sqr_reg[k-1]} + {1'b0, bitv};
            if ({1'b0, sqn_reg[k-1]} >= t) begin
                sqn_next[k] = sqn_reg[k-1] - t[SQW-1:0];
                sqr_next[k] = (sqr_reg[k-1] >> 1) + bitv;
            end
            else begin
                sqn_next[k] = sqn_reg[k-1];
                sqr_next[k] = sqr_reg[k-1] >> 1;
            end
        end
    end

    // restoring divider, four lanes, one quotient bit per stage
    always_comb
    begin
        logic [DW-1:0] dd;
        logic [LW:0]   t;
        dvl_src[0] = sqr_reg[SQ_END][LW-1:0];
        for (int i = 0; i < 4; i++) begin
            dd             = {nm_reg[SQ_END][i], {F{1'b0}}};
            dvr_src[0][i]  = LW'(dd[DW-1:DIV_STEPS]);
            dvlo_src[0][i] = dd[DIV_STEPS-1:0];
            dvq_src[0][i]  = '0;
        end
        for (int k = 1; k < DIV_STEPS; k++) begin
            dvl_src[k]  = dvl_reg[k];
            dvr_src[k]  = dvr_reg[k];
            dvlo_src[k] = dvlo_reg[k];
            dvq_src[k]  = dvq_reg[k];
        end
        for (int k = 1; k <= DIV_STEPS; k++) begin
            dvl_next[k] = dvl_src[k-1];
            for (int i = 0; i < 4; i++) begin
                t = {dvr_src[k-1][i], dvlo_src[k-1][i][DIV_STEPS-1]};
                dvlo_next[k][i] = dvlo_src[k-1][i] << 1;
                if (t >= {1'b0, dvl_src[k-1]}) begin
                    dvr_next[k][i] = LW'(t - {1'b0, dvl_src[k-1]});
                    dvq_next[k][i] = {dvq_src[k-1][i][DIV_STEPS-2:0], 1'b1};
                end
                else begin
                    dvr_next[k][i] = t[LW-1:0];
                    dvq_next[k][i] = {dvq_src[k-1][i][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    // output select
    always_comb
    begin
        logic [DIV_STEPS:0]     q1;
        logic signed [WIDE-1:0] vs;
        logic [W:0]             sv;
        logic                   f;
        f = 1'b0;
        for (int i = 0; i < 4; i++) begin
            q1 = {1'b0, dvq_reg[DIV_STEPS][i]}
               + (({dvr_reg[DIV_STEPS][i], 1'b0} >= {1'b0, dvl_reg[DIV_STEPS]}) ?
                  (DIV_STEPS+1)'(1) : (DIV_STEPS+1)'(0));
            vs = $signed(WIDE'(q1));
            if (ctl_reg[LAST].neg[i]) begin
                vs = -vs;
            end
            sv = qau_pkg::sat_wide(vs);
            f  = f | sv[W];
            if (ctl_reg[LAST].kind == qau_pkg::KIND_NORMALIZE) begin
                out_data_next[i*W +: W] = ctl_reg[LAST].zero ? '0 : sv[W-1:0];
            end
            else begin
                out_data_next[i*W +: W] = mres_reg[LAST][i];
            end
        end
        if (ctl_reg[LAST].kind == qau_pkg::KIND_NORMALIZE) begin
            if (ctl_reg[LAST].zero) begin
                out_user_next = qau_pkg::ST_ZERO;
            end
            else begin
                out_user_next = f ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
            end
        end
        else begin
            out_user_next = mflag_reg[LAST] ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 1; k <= LAST; k++) begin
                ctl_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv) begin
            ctl_reg       <= ctl_next;
            out_valid_reg <= ctl_reg[LAST].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            a1_reg    <= a1_next;
            b1_reg    <= b1_next;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
            prod_reg  <= prod_next;
            mag2_reg  <= mag2_next;
            orv2_reg  <= orv2_next;
            mag3_reg  <= mag2_reg;
            mag4_reg  <= mag3_reg;
            fx3_reg   <= fx3_next;
            flag3_reg <= flag3_next;
            grp3_reg  <= grp3_next;
            r4_reg    <= r4_next;
            m4_reg    <= m4_next;
            for (int j = 0; j < 3; j++) begin
                b4_reg[j] <= b3_reg[j];
            end
            flag4_reg  <= flag4_next;
            bl4_reg    <= bl4_next;
            prod5_reg  <= prod5_next;
            r5_reg     <= r4_reg;
            flag5_reg  <= flag4_reg;
            fx6_reg    <= fx6_next;
            r6_reg     <= r5_reg;
            flag6_reg  <= flag6_next;
            sq6_reg    <= sq6_next;
            nm_reg[5]  <= nm5_next;
            for (int k = 6; k <= SQ_END; k++) begin
                nm_reg[k] <= nm_reg[k-1];
            end
            mres_reg[MAIN_END]  <= r7_next;
            mflag_reg[MAIN_END] <= flag7_next;
            for (int k = MAIN_END + 1; k <= LAST; k++) begin
                mres_reg[k]  <= mres_reg[k-1];
                mflag_reg[k] <= mflag_reg[k-1];
            end
            sqn_reg      <= sqn_next;
            sqr_reg      <= sqr_next;
            dvr_reg      <= dvr_next;
            dvlo_reg     <= dvlo_next;
            dvq_reg      <= dvq_next;
            dvl_reg      <= dvl_next;
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    a_zero_clears_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == qau_pkg::ST_ZERO) |-> (m_tdata == '0))
        else $error("normalize error with nonzero data");

    a_rot_r3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ctl_reg[LAST].valid && ctl_reg[LAST].kind == qau_pkg::KIND_ROT)
        |=> (m_tdata[4*W-1:3*W] == '0))
        else $error("rotation result with nonzero r3");

    a_zero_only_normalize: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ctl_reg[LAST].valid && ctl_reg[LAST].kind != qau_pkg::KIND_NORMALIZE)
        |=> (m_tuser != qau_pkg::ST_ZERO))
        else $error("zero status outside normalize");

    a_norm_sq_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ctl_reg[LAST].valid && ctl_reg[LAST].kind == qau_pkg::KIND_NORM_SQ)
        |=> (m_tdata[4*W-1:W] == '0))
        else $error("squared norm with nonzero upper components");

endmodule

// File: bench/tb_quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_quaternion_arithmetic_unit
// Streams directed and random quaternion transactions of every kind through
// the unit and checks each result against a bit-exact fixed-point predictor,
// under phases of no idling, source gaps, sink stalls and light mixed idling.
// ----------------------------------------------------------------------------
module tb_quaternion_arithmetic_unit;

    typedef logic signed [127:0] big_t;
    typedef struct {
        logic [2:0]     kind;
        qau_pkg::word_t a [4];
        qau_pkg::word_t b [4];
    } op_t;
    typedef struct {
        qau_pkg::word_t r [4];
        logic [1:0]     status;
    } res_t;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int N_RANDOM = 1030;
    localparam int IDLE_LIMIT = 4000;

    // sign-coded term tables: +-(index+1)
    localparam int HAM_TERM [4][4] = '{'{1, -2, -3, -4}, '{2, 1, 4, -3},
                                       '{3, -4, 1, 2}, '{4, 3, -2, 1}};
    localparam int OMEGA_TERM [2][4][3] = '{
        '{'{-2, -3, -4}, '{1, 4, -3}, '{-4, 1, 2}, '{3, -2, 1}},
        '{'{-2, -3, -4}, '{1, -4, 3}, '{4, 1, -2}, '{-3, 2, 1}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [8*qau_pkg::DATA_W-1:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [4*qau_pkg::DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    op_t pending_ops [$];
    res_t expected_results [$];
    int total_ops;
    int sent_cnt = 0;
    int drv_cnt = 0;
    int recv_cnt = 0;
    int err_cnt = 0;
    int idle_cycles = 0;
    int kind_cnt [8];
    bit sat_seen;
    bit stim_done = 0;

    quaternion_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic qau_pkg::word_t clamp(big_t v);
        big_t hi, lo;
        hi = 128'sd2147483647;
        lo = -128'sd2147483648;
        if (v > hi)
        begin
            sat_seen = 1;
            return qau_pkg::word_t'(hi);
        end
        if (v < lo)
        begin
            sat_seen = 1;
            return qau_pkg::word_t'(lo);
        end
        return qau_pkg::word_t'(v);
    endfunction

    function automatic qau_pkg::word_t fx_mul(qau_pkg::word_t x, qau_pkg::word_t y);
        big_t bx, by, p;
        bx = x;
        by = y;
        p = bx * by + (big_t'(1) <<< (qau_pkg::FRAC_W - 1));
        return clamp(p >>> qau_pkg::FRAC_W);
    endfunction

    function automatic big_t signed_term(qau_pkg::word_t v, int code);
        big_t t;
        t = v;
        return (code < 0) ? -t : t;
    endfunction

    function automatic qau_pkg::word_t rot_entry(qau_pkg::word_t w, qau_pkg::word_t x,
                                                 int sx, qau_pkg::word_t y, int sy,
                                                 qau_pkg::word_t z, int sz);
        big_t s;
        s = w;
        s = s + signed_term(x, sx) + signed_term(y, sy) + signed_term(z, sz);
        return clamp(s);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root, probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic res_t quat_predict(op_t op);
        res_t res;
        qau_pkg::word_t p [4][4];
        qau_pkg::word_t m [3][3];
        big_t s;
        logic [63:0] mag [4];
        logic [63:0] mx, sum, len, q, rem, num;
        int bl, code, t;
        sat_seen = 0;
        res.status = qau_pkg::ST_OK;
        for (int i = 0; i < 4; i++) res.r[i] = '0;
        case (op.kind)
            qau_pkg::KIND_CONJ:
            begin
                res.r[0] = op.a[0];
                for (int i = 1; i < 4; i++) res.r[i] = clamp(-big_t'(op.a[i]));
            end
            qau_pkg::KIND_MUL:
                for (int i = 0; i < 4; i++)
                begin
                    s = 0;
                    for (int j = 0; j < 4; j++)
                    begin
                        code = HAM_TERM[i][j];
                        s = s + signed_term(fx_mul(op.a[j], op.b[(code < 0 ? -code : code) - 1]),
                                            code);
                    end
                    res.r[i] = clamp(s);
                end
            qau_pkg::KIND_ROT:
            begin
                for (int i = 0; i < 4; i++)
                    for (int j = i; j < 4; j++)
                    begin
                        p[i][j] = fx_mul(op.a[i], op.a[j]);
                        p[j][i] = p[i][j];
                    end
                m[0][0] = rot_entry(p[0][0], p[1][1], 1, p[2][2], -1, p[3][3], -1);
                m[1][1] = rot_entry(p[0][0], p[1][1], -1, p[2][2], 1, p[3][3], -1);
                m[2][2] = rot_entry(p[0][0], p[1][1], -1, p[2][2], -1, p[3][3], 1);
                m[0][1] = rot_entry(p[1][2], p[1][2], 1, p[0][3], -1, p[0][3], -1);
                m[0][2] = rot_entry(p[1][3], p[1][3], 1, p[0][2], 1, p[0][2], 1);
                m[1][0] = rot_entry(p[1][2], p[1][2], 1, p[0][3], 1, p[0][3], 1);
                m[1][2] = rot_entry(p[2][3], p[2][3], 1, p[0][1], -1, p[0][1], -1);
                m[2][0] = rot_entry(p[1][3], p[1][3], 1, p[0][2], -1, p[0][2], -1);
                m[2][1] = rot_entry(p[2][3], p[2][3], 1, p[0][1], 1, p[0][1], 1);
                for (int i = 0; i < 3; i++)
                begin
                    s = 0;
                    for (int j = 0; j < 3; j++) s = s + fx_mul(m[i][j], op.b[j]);
                    res.r[i] = clamp(s);
                end
            end
            qau_pkg::KIND_RATE_G, qau_pkg::KIND_RATE_L:
            begin
                t = (op.kind == qau_pkg::KIND_RATE_G) ? 0 : 1;
                for (int i = 0; i < 4; i++)
                begin
                    s = 0;
                    for (int j = 0; j < 3; j++)
                    begin
                        code = OMEGA_TERM[t][i][j];
                        s = s + signed_term(fx_mul(op.a[(code < 0 ? -code : code) - 1], op.b[j]),
                                            code);
                    end
                    res.r[i] = clamp((s + 1) >>> 1);
                end
            end
            qau_pkg::KIND_NORM_SQ:
            begin
                s = 0;
                for (int i = 0; i < 4; i++) s = s + fx_mul(op.a[i], op.a[i]);
                res.r[0] = clamp(s);
            end
            qau_pkg::KIND_NORMALIZE:
            begin
                mx = 0;
                for (int i = 0; i < 4; i++)
                begin
                    mag[i] = op.a[i] < 0 ? 64'(-big_t'(op.a[i])) : 64'(op.a[i]);
                    if (mag[i] > mx) mx = mag[i];
                end
                if (mx == 0)
                    res.status = qau_pkg::ST_ZERO;
                else
                begin
                    bl = 0;
                    while (bl < 64 && (mx >> bl) != 0) bl++;
                    sum = 0;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (bl > qau_pkg::NORM_BITS)
                            mag[i] = mag[i] >> (bl - qau_pkg::NORM_BITS);
                        else
                            mag[i] = mag[i] << (qau_pkg::NORM_BITS - bl);
                        sum = sum + mag[i] * mag[i];
                    end
                    len = int_sqrt(sum);
                    for (int i = 0; i < 4; i++)
                    begin
                        num = mag[i] << qau_pkg::FRAC_W;
                        q = num / len;
                        rem = num % len;
                        if (2 * rem >= len) q = q + 1;
                        s = big_t'({64'd0, q});
                        res.r[i] = clamp(op.a[i] < 0 ? -s : s);
                    end
                end
            end
            default: ;
        endcase
        if (res.status == qau_pkg::ST_OK && sat_seen) res.status = qau_pkg::ST_SAT;
        return res;
    endfunction

    function automatic qau_pkg::word_t rand_word();
        case ($urandom_range(0, 9))
            0: return qau_pkg::word_t'(32'h8000_0000 + $urandom_range(0, 3));
            1: return qau_pkg::word_t'(32'h7FFF_FFFF - $urandom_range(0, 3));
            2: return qau_pkg::word_t'($urandom_range(0, 8));
            3, 4, 5: return qau_pkg::word_t'(int'($urandom_range(0, 33554432)) - 16777216);
            6: return -qau_pkg::word_t'($urandom_range(0, 255));
            default: return qau_pkg::word_t'($urandom);
        endcase
    endfunction

    task automatic add_op(logic [2:0] kind, qau_pkg::word_t a0, qau_pkg::word_t a1,
                          qau_pkg::word_t a2, qau_pkg::word_t a3, qau_pkg::word_t b0,
                          qau_pkg::word_t b1, qau_pkg::word_t b2, qau_pkg::word_t b3);
        op_t op;
        op.kind = kind;
        op.a = '{a0, a1, a2, a3};
        op.b = '{b0, b1, b2, b3};
        pending_ops.push_back(op);
    endtask

    // source side and sink ready: hold the item until taken, advance at falling edge
    always @(negedge clk)
    begin
        int src_idle, snk_stall, phase;
        op_t op;
        phase = (sent_cnt * 4) / (total_ops + 1);
        src_idle = (phase == 1) ? 57 : (phase == 3) ? 6 : 0;
        snk_stall = (phase == 2) ? 57 : (phase == 3) ? 6 : 0;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall);
            if (drv_cnt == sent_cnt)
            begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= src_idle)
                begin
                    op = pending_ops[0];
                    s_tdata <= {op.b[3], op.b[2], op.b[1], op.b[0],
                                op.a[3], op.a[2], op.a[1], op.a[0]};
                    s_tuser <= op.kind;
                    s_tvalid <= 1'b1;
                    drv_cnt++;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        qau_pkg::word_t got;
        bit moved;
        moved = 0;
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_results.push_back(quat_predict(pending_ops[0]));
            kind_cnt[pending_ops[0].kind]++;
            pending_ops.pop_front();
            sent_cnt++;
            moved = 1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            moved = 1;
            recv_cnt++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction r=%h status=%0d", m_tdata, m_tuser);
                err_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    got = m_tdata[i*qau_pkg::DATA_W +: qau_pkg::DATA_W];
                    if (got !== want.r[i])
                    begin
                        $error("r%0d mismatch: expected %h, actual %h", i, want.r[i], got);
                        err_cnt++;
                    end
                end
                if (m_tuser !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                    err_cnt++;
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (rst_n && idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress, %0d sent, %0d received", sent_cnt, recv_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        qau_pkg::word_t one, mn, mx;
        int k;
        one = 32'sh0100_0000;
        mn = 32'sh8000_0000;
        mx = 32'sh7FFF_FFFF;
        foreach (kind_cnt[i]) kind_cnt[i] = 0;
        add_op(qau_pkg::KIND_CONJ, mn, mn, mx, 0, 0, 0, 0, 0);
        add_op(qau_pkg::KIND_CONJ, one, -one, 1, -1, mx, mn, 0, 0);
        add_op(qau_pkg::KIND_MUL, one, 0, 0, 0, 0, one, 0, 0);
        add_op(qau_pkg::KIND_MUL, 0, one, one, one, 0, one, -one, one);
        add_op(qau_pkg::KIND_MUL, mx, mn, mx, mn, mn, mx, mn, mx);
        add_op(qau_pkg::KIND_ROT, one, 0, 0, 0, one, -one, one, mx);
        add_op(qau_pkg::KIND_ROT, 32'sh00B5_04F3, 0, 0, 32'sh00B5_04F3, one, 0, 0, 0);
        add_op(qau_pkg::KIND_ROT, mx, mn, mx, mn, mx, mx, mn, 0);
        add_op(qau_pkg::KIND_RATE_G, one, one, 0, 0, one, one, one, 0);
        add_op(qau_pkg::KIND_RATE_G, mx, mn, mx, mn, mn, mn, mx, mx);
        add_op(qau_pkg::KIND_RATE_L, one, 0, one, 0, one, -one, one, 0);
        add_op(qau_pkg::KIND_RATE_L, mn, mn, mn, mn, mn, mn, mn, mn);
        add_op(qau_pkg::KIND_NORM_SQ, one, one, one, one, 0, 0, 0, 0);
        add_op(qau_pkg::KIND_NORM_SQ, mn, 0, 0, 0, 0, 0, 0, 0);
        add_op(qau_pkg::KIND_NORMALIZE, 0, 0, 0, 0, mx, mx, mx, mx);
        add_op(qau_pkg::KIND_NORMALIZE, 0, 0, 0, 1, 0, 0, 0, 0);
        add_op(qau_pkg::KIND_NORMALIZE, 0, -1, 0, 0, 0, 0, 0, 0);
        add_op(qau_pkg::KIND_NORMALIZE, mn, mn, mn, mn, 0, 0, 0, 0);
        add_op(qau_pkg::KIND_NORMALIZE, mx, 0, 0, 0, 0, 0, 0, 0);
        add_op(qau_pkg::KIND_NORMALIZE, 3, -4, 0, 0, 0, 0, 0, 0);
        add_op(qau_pkg::KIND_NORMALIZE, one, 2 * one, -one, mn, 0, 0, 0, 0);
        add_op(KIND_UNUSED, mx, mn, one, -1, mx, mn, one, -1);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            k = $urandom_range(0, 7);
            if (k == 7 && $urandom_range(0, 3) != 0) k = $urandom_range(0, 6);
            if (k == qau_pkg::KIND_NORMALIZE && $urandom_range(0, 19) == 0)
                add_op(qau_pkg::KIND_NORMALIZE, 0, 0, 0, 0, rand_word(), rand_word(), 0, 0);
            else
                add_op(k[2:0], rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word(), rand_word());
        end
        total_ops = pending_ops.size();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (sent_cnt == total_ops && expected_results.size() == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d transactions: conj %0d mul %0d rot %0d rate %0d/%0d",
                 sent_cnt, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], kind_cnt[4]);
        $display("  norm squared %0d, normalize %0d, unused code %0d, errors %0d",
                 kind_cnt[5], kind_cnt[6], kind_cnt[7], err_cnt);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
